FILE: rtl/core/xrs_pkg.sv
// ----------------------------------------------------------------------------
// xrs_pkg
// Shared types and constants of the xorshift64* random source.
// ----------------------------------------------------------------------------
`default_nettype none

package xrs_pkg;

    localparam logic [63:0] MULT_STAR   = 64'd2685821657736338717;
    localparam logic [63:0] GOLDEN      = 64'h9e3779b97f4a7c15;
    localparam logic [31:0] CHUNK_MUL_X = 32'd123456789;
    localparam logic [31:0] CHUNK_MUL_Z = 32'd987654321;
    localparam logic [63:0] SEED_RESET  = 64'hdeadbeefcafebabe;
    localparam int          FRAC_SHIFT  = 11;

    typedef enum logic [2:0] {
        ACT_RAW        = 3'd0,
        ACT_RANGED     = 3'd1,
        ACT_FRAC       = 3'd2,
        ACT_SEED_WORLD = 3'd3,
        ACT_SEED_CHUNK = 3'd4
    } act_t;

    typedef enum logic [2:0] {
        OPND_NONE,
        OPND_DRAW,
        OPND_CX,
        OPND_CZ,
        OPND_MIX
    } opnd_sel_t;

    typedef enum logic [1:0] {
        PART_NONE,
        PART_LL,
        PART_LH,
        PART_HL
    } mul_part_t;

    typedef enum logic [1:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD_HI
    } acc_op_t;

    typedef struct packed {
        logic      latch;
        opnd_sel_t opnd;
        logic      advance;
        mul_part_t part;
        acc_op_t   acc;
        logic      keep_x;
        logic      mix_load;
        logic      seed_world;
        logic      seed_chunk;
        logic      div_start;
        logic      result_load;
    } dp_cmd_t;

    typedef struct packed {
        logic [2:0] action;
        logic       range_bad;
        logic       div_done;
        logic       out_busy;
    } dp_sts_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_OPND,
        ST_M_LL,
        ST_M_LH,
        ST_M_HL,
        ST_M_END,
        ST_DIV,
        ST_CX_MUL,
        ST_CX_KEEP,
        ST_CZ_MUL,
        ST_CZ_MIX,
        ST_MIX_OPND,
        ST_CHUNK_SET,
        ST_RESULT
    } ctrl_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/xrs_moddiv.sv
// ----------------------------------------------------------------------------
// xrs_moddiv
// Restoring remainder unit: 64-bit dividend by 32-bit divisor, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module xrs_moddiv (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [63:0] dividend,
    input  wire logic [31:0] divisor,
    output logic             done,
    output logic [31:0]      remainder
);
    localparam int STEPS = 64;
    localparam int CNT_W = $clog2(STEPS);

    logic [63:0]      quo_reg, quo_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      div_reg, div_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [32:0]      trial;
    logic [32:0]      diff;

    always_comb begin
        trial     = {rem_reg, quo_reg[63]};
        diff      = trial - {1'b0, div_reg};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            quo_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            quo_next = {quo_reg[62:0], 1'b0};
            rem_next = (trial >= {1'b0, div_reg}) ? diff[31:0] : trial[31:0];
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(STEPS - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

`default_nettype wire

FILE: rtl/core/xrs_datapath.sv
// ----------------------------------------------------------------------------
// xrs_datapath
// Generator state, seed register, shared 32x32 multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module xrs_datapath (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire xrs_pkg::dp_cmd_t cmd,
    output xrs_pkg::dp_sts_t      sts,
    input  wire logic             cfg_wr_en,
    input  wire logic [63:0]      cfg_wr_data,
    input  wire logic [127:0]     s_tdata,
    input  wire logic [2:0]       s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic [95:0]           m_tdata,
    output logic [0:0]            m_tuser
);
    import xrs_pkg::*;

    logic [63:0] state_reg, state_next;
    logic [63:0] seed_reg;
    logic [2:0]  action_reg;
    logic [31:0] lo_reg, hi_reg, cx_reg, cz_reg;
    logic [63:0] opa_reg, opb_reg;
    logic [63:0] prod_reg;
    logic [63:0] acc_reg;
    logic [31:0] mx_reg;
    logic [63:0] c_reg;
    logic        out_valid_reg;
    logic [63:0] raw_reg;
    logic [31:0] int_reg;
    logic        err_reg;

    logic [63:0] xs1, xs2, xs3;
    logic [31:0] mul_x, mul_y;
    logic [63:0] mul_p;
    logic [63:0] chunk_sum;
    logic [31:0] span;
    logic        range_bad;
    logic        div_done;
    logic [31:0] div_rem;
    logic [63:0] div_dividend;

    always_comb begin
        xs1 = state_reg ^ (state_reg >> 12);
        xs2 = xs1 ^ (xs1 << 25);
        xs3 = xs2 ^ (xs2 >> 27);
        state_next = state_reg;
        if (cmd.advance) begin
            state_next = xs3;
        end else if (cmd.seed_world) begin
            state_next = (seed_reg == 64'd0) ? GOLDEN : seed_reg;
        end else if (cmd.seed_chunk) begin
            state_next = c_reg ^ acc_reg;
        end
    end

    always_comb begin
        mul_x = opa_reg[31:0];
        mul_y = opb_reg[31:0];
        case (cmd.part)
            PART_LH: mul_y = opb_reg[63:32];
            PART_HL: mul_x = opa_reg[63:32];
            default: mul_x = opa_reg[31:0];
        endcase
        mul_p = {32'd0, mul_x} * {32'd0, mul_y};
    end

    assign chunk_sum = {{32{mx_reg[31]}}, mx_reg} + {{32{prod_reg[31]}}, prod_reg[31:0]};
    assign span      = hi_reg - lo_reg + 32'd1;
    assign range_bad = ($signed(hi_reg) < $signed(lo_reg)) || (span == 32'd0);

    // fold in the last partial product as the divider loads
    assign div_dividend = {acc_reg[63:32] + prod_reg[31:0], acc_reg[31:0]};

    xrs_moddiv u_moddiv (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .dividend  (div_dividend),
        .divisor   (span),
        .done      (div_done),
        .remainder (div_rem)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= '0;
            seed_reg      <= SEED_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                seed_reg <= cfg_wr_data;
            end
            if (cmd.result_load) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch) begin
            action_reg <= s_tuser;
            lo_reg     <= s_tdata[31:0];
            hi_reg     <= s_tdata[63:32];
            cx_reg     <= s_tdata[95:64];
            cz_reg     <= s_tdata[127:96];
        end
        case (cmd.opnd)
            OPND_DRAW: begin
                opa_reg <= state_reg;
                opb_reg <= MULT_STAR;
            end
            OPND_CX: begin
                opa_reg <= {32'd0, cx_reg};
                opb_reg <= {32'd0, CHUNK_MUL_X};
            end
            OPND_CZ: begin
                opa_reg <= {32'd0, cz_reg};
                opb_reg <= {32'd0, CHUNK_MUL_Z};
            end
            OPND_MIX: begin
                opa_reg <= {33'd0, c_reg[63:33]};
                opb_reg <= GOLDEN;
            end
            default: begin
                opa_reg <= opa_reg;
            end
        endcase
        if (cmd.part != PART_NONE) begin
            prod_reg <= mul_p;
        end
        case (cmd.acc)
            ACC_LOAD:   acc_reg <= prod_reg;
            ACC_ADD_HI: acc_reg[63:32] <= acc_reg[63:32] + prod_reg[31:0];
            default:    acc_reg <= acc_reg;
        endcase
        if (cmd.keep_x) begin
            mx_reg <= prod_reg[31:0];
        end
        if (cmd.mix_load) begin
            c_reg <= seed_reg ^ chunk_sum;
        end
        if (cmd.result_load) begin
            case (action_reg)
                ACT_RAW: begin
                    raw_reg <= acc_reg;
                    int_reg <= '0;
                    err_reg <= 1'b0;
                end
                ACT_RANGED: begin
                    raw_reg <= acc_reg;
                    int_reg <= range_bad ? lo_reg : lo_reg + div_rem;
                    err_reg <= range_bad;
                end
                ACT_FRAC: begin
                    raw_reg <= acc_reg >> FRAC_SHIFT;
                    int_reg <= '0;
                    err_reg <= 1'b0;
                end
                default: begin
                    raw_reg <= '0;
                    int_reg <= '0;
                    err_reg <= 1'b0;
                end
            endcase
        end
    end

    assign sts.action    = action_reg;
    assign sts.range_bad = range_bad;
    assign sts.div_done  = div_done;
    assign sts.out_busy  = out_valid_reg && !m_tready;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {int_reg, raw_reg};
    assign m_tuser  = err_reg;

endmodule

`default_nettype wire

FILE: rtl/core/xrs_ctrl.sv
// ----------------------------------------------------------------------------
// xrs_ctrl
// Sequencer: steps draws through advance, multiply, optional reduce and result; reseeds take their own path.
// ----------------------------------------------------------------------------
`default_nettype none

module xrs_ctrl (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire xrs_pkg::dp_sts_t sts,
    output xrs_pkg::dp_cmd_t      cmd
);
    import xrs_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.latch  = 1'b1;
                    state_next = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                case (sts.action)
                    ACT_RAW, ACT_RANGED, ACT_FRAC: begin
                        cmd.advance = 1'b1;
                        state_next  = ST_OPND;
                    end
                    ACT_SEED_WORLD: begin
                        cmd.seed_world = 1'b1;
                        state_next     = ST_RESULT;
                    end
                    ACT_SEED_CHUNK: begin
                        cmd.opnd   = OPND_CX;
                        state_next = ST_CX_MUL;
                    end
                    default: state_next = ST_RESULT;
                endcase
            end
            ST_OPND: begin
                cmd.opnd   = OPND_DRAW;
                state_next = ST_M_LL;
            end
            ST_M_LL: begin
                cmd.part   = PART_LL;
                state_next = ST_M_LH;
            end
            ST_M_LH: begin
                cmd.part   = PART_LH;
                cmd.acc    = ACC_LOAD;
                state_next = ST_M_HL;
            end
            ST_M_HL: begin
                cmd.part   = PART_HL;
                cmd.acc    = ACC_ADD_HI;
                state_next = ST_M_END;
            end
            ST_M_END: begin
                cmd.acc = ACC_ADD_HI;
                if (sts.action == ACT_SEED_CHUNK) begin
                    state_next = ST_CHUNK_SET;
                end else if (sts.action == ACT_RANGED && !sts.range_bad) begin
                    state_next = ST_DIV;
                end else begin
                    state_next = ST_RESULT;
                end
            end
            ST_DIV: begin
                if (sts.div_done) begin
                    state_next = ST_RESULT;
                end
            end
            ST_CX_MUL: begin
                cmd.part   = PART_LL;
                state_next = ST_CX_KEEP;
            end
            ST_CX_KEEP: begin
                cmd.keep_x = 1'b1;
                cmd.opnd   = OPND_CZ;
                state_next = ST_CZ_MUL;
            end
            ST_CZ_MUL: begin
                cmd.part   = PART_LL;
                state_next = ST_CZ_MIX;
            end
            ST_CZ_MIX: begin
                cmd.mix_load = 1'b1;
                state_next   = ST_MIX_OPND;
            end
            ST_MIX_OPND: begin
                cmd.opnd   = OPND_MIX;
                state_next = ST_M_LL;
            end
            ST_CHUNK_SET: begin
                cmd.seed_chunk = 1'b1;
                state_next     = ST_RESULT;
            end
            ST_RESULT: begin
                if (!sts.out_busy) begin
                    cmd.result_load = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (state_reg == ST_M_END && state_next == ST_DIV) begin
            cmd.div_start = 1'b1;
        end
    end

`ifndef SYNTHESIS
    a_div_only_valid_span: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.div_start |-> (sts.action == ACT_RANGED && !sts.range_bad))
        else $error("divider started without a valid span");

    a_no_result_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.result_load |-> !sts.out_busy)
        else $error("result loaded while output still stalled");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> state_reg == ST_DISPATCH)
        else $error("accepted request not dispatched");

    a_div_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DIV && !sts.div_done) |=> state_reg == ST_DIV)
        else $error("left divide wait before remainder ready");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/xorshift64star_random_source.sv
// ----------------------------------------------------------------------------
// xorshift64star_random_source
// xorshift64* generator with raw, ranged, fraction and reseed requests.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on s_*: s_tuser holds the action, s_tdata the bounds and
//   chunk coordinates. Each request produces exactly one result on m_*.
//   cfg_wr_en / cfg_wr_data load the world seed; write only while idle.
// Request paths:
//   raw and fraction draws form the 64-bit product as three 32x32
//   partial products on one shared multiplier; ranged draws with a
//   valid span then run the restoring remainder unit, one bit per
//   cycle. An invalid span (hi below lo, or one that wraps to zero)
//   skips the divider. World reseed loads the seed (GOLDEN if zero);
//   chunk reseed mixes the seed and chunk coordinates on the multiplier.
// Flow: one request is in flight at a time; the next is accepted the
//   cycle after the previous result loads into the output register.
// Reset: generator state clears to zero, world seed returns to its default,
//   no result is pending.
// Stall: while m_tready is low the result holds; a finished second request
//   waits in the sequencer until the output register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module xorshift64star_random_source (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         cfg_wr_en,
    input  wire logic [63:0]  cfg_wr_data,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    input  wire logic [127:0] s_tdata,   // lo, hi, chunk_x, chunk_z
    input  wire logic [2:0]   s_tuser,   // action
    output logic              m_tvalid,
    input  wire logic         m_tready,
    output logic [95:0]       m_tdata,   // raw_value, int_value
    output logic [0:0]        m_tuser    // range_error
);
    import xrs_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    xrs_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    xrs_datapath u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .sts         (sts),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser)
    );

endmodule

`default_nettype wire
